/* hdl/sorted_timer_task_queue_core_assert.svh */
// ----------------------------------------------------------------------------
// Timer task queue assertion macros
// Concurrent checks that compile to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_TASK_QUEUE_CORE_ASSERT_SVH
`define SORTED_TIMER_TASK_QUEUE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define STTQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define STTQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STTQ_ASSERT(lbl, prop, msg)
`define STTQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/sttq_pkg.sv */
// ----------------------------------------------------------------------------
// Timer task queue package
// Entry layout, id width and result status codes.
// ----------------------------------------------------------------------------
package sttq_pkg;

    localparam int ID_W = 23;

    typedef struct packed {
        logic [63:0]     due_time;
        logic [ID_W-1:0] task_id;
        logic [31:0]     handler_ref;
        logic [31:0]     argument_ref;
    } entry_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ARGS   = 3'd1,
        ST_FULL       = 3'd2,
        ST_INVALID_ID = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } op_status_t;

endpackage

/* hdl/sttq_mem.sv */
// ----------------------------------------------------------------------------
// Timer task queue entry memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sttq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  sttq_pkg::entry_t  wr_data,
    input  logic [AW-1:0]     rd_addr,
    output sttq_pkg::entry_t  rd_data
);
    import sttq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/sorted_timer_task_queue_core.sv */
// ----------------------------------------------------------------------------
// Sorted timer task queue
// Keeps timed tasks in due-time order in one entry memory; submit and cancel.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one submit or cancel per transfer.
// Output channel (out_valid/out_ready): one result per operation with
// status, assigned_id and entry_count after the operation.
// One operation at a time; in_ready is high only when idle. With N entries
// queued, each entry visited takes a read state and a check state on the
// single memory read port. Steps from input transfer to out_valid:
//   submit: id search per candidate id (usually one), then unless full
//           shift entries later than due_time up from the tail, insert.
//   cancel: id search, then shift the entries after it down. Rejected
// operations go straight to the result; in_ready returns with out_valid.
// Reset empties the queue and clears the id counter at once; no clearing
// pass, entries at or above the count are never used.
// A stalled result waits in the output register; the next operation is
// still taken and runs until its own result is due.
// ----------------------------------------------------------------------------
`include "sorted_timer_task_queue_core_assert.svh"

module sorted_timer_task_queue_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [63:0]                        due_time,
    input  logic [31:0]                        handler_ref,
    input  logic [31:0]                        argument_ref,
    input  logic signed [23:0]                 cancel_id,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         status,
    output logic [sttq_pkg::ID_W-1:0]          assigned_id,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   entry_count
);
    import sttq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ID_RD,     // id search: read entry idx
        S_ID_CHK,    // id search: compare against candidate
        S_INS_RD,    // insert: read entry idx-1 (walks down from the tail)
        S_INS_CHK,   // insert: shift up or drop new entry in
        S_CAN_RD,    // cancel: read entry idx
        S_CAN_CHK,   // cancel: compare id
        S_SHF_RD,    // cancel: read entry idx+1
        S_SHF_WR,    // cancel: move it down to idx
        S_RESP
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   len_reg;
    logic [CW-1:0]   idx_reg;
    logic [ID_W-1:0] last_id_reg;
    logic [ID_W-1:0] cand_reg;
    logic [ID_W-1:0] cid_reg;
    entry_t          new_reg;
    op_status_t      res_status_reg;
    logic [ID_W-1:0] res_id_reg;

    logic            out_valid_reg;
    op_status_t      status_reg;
    logic [ID_W-1:0] assigned_id_reg;
    logic [CW-1:0]   entry_count_reg;

    // memory port
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;
    logic [CW-1:0]   rd_idx;
    entry_t          rd_data;

    logic            later;
    logic            in_xfer;

    // result held by a stalled receiver
    logic                  out_hold;
    logic [ID_W+CW+2:0]    out_word;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign later    = (rd_data.due_time > new_reg.due_time);

    // Read address follows the state; writes never target the entry being
    // read in the same or next step, so no forwarding is needed.
    always_comb
    begin
        case (state_reg)
            S_INS_RD: rd_idx = idx_reg - CW'(1);
            S_SHF_RD: rd_idx = idx_reg + CW'(1);
            default:  rd_idx = idx_reg;
        endcase
    end

    always_comb
    begin
        wr_addr = idx_reg[AW-1:0];
        wr_data = new_reg;
        wr_en   = 1'b0;
        case (state_reg)
            S_INS_RD:
            begin
                wr_en = (idx_reg == '0);
            end
            S_INS_CHK:
            begin
                wr_en = 1'b1;
                if (later)
                begin
                    wr_data = rd_data;
                end
            end
            S_SHF_WR:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    sttq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            len_reg         <= '0;
            last_id_reg     <= '0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
            cand_reg        <= '0;
            cid_reg         <= '0;
            new_reg         <= '0;
            res_status_reg  <= ST_OK;
            res_id_reg      <= '0;
            status_reg      <= ST_OK;
            assigned_id_reg <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            // S_RESP drives out_valid_reg itself
            if (out_valid_reg && out_ready && (state_reg != S_RESP))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        new_reg.due_time     <= due_time;
                        new_reg.handler_ref  <= handler_ref;
                        new_reg.argument_ref <= argument_ref;
                        idx_reg              <= '0;
                        res_id_reg           <= '0;
                        cid_reg              <= cancel_id[ID_W-1:0];
                        cand_reg             <= last_id_reg + ID_W'(1);
                        if (!operation)
                        begin
                            if (handler_ref == '0)
                            begin
                                res_status_reg <= ST_BAD_ARGS;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                state_reg <= S_ID_RD;
                            end
                        end
                        else if (cancel_id[23])
                        begin
                            res_status_reg <= ST_INVALID_ID;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_CAN_RD;
                        end
                    end
                end
                S_ID_RD:
                begin
                    if (idx_reg == len_reg)
                    begin
                        // candidate is free
                        last_id_reg      <= cand_reg;
                        new_reg.task_id  <= cand_reg;
                        if (len_reg == FULL_CNT)
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            idx_reg   <= len_reg;
                            state_reg <= S_INS_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_ID_CHK;
                    end
                end
                S_ID_CHK:
                begin
                    if (rd_data.task_id == cand_reg)
                    begin
                        cand_reg <= cand_reg + ID_W'(1);
                        idx_reg  <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    state_reg <= S_ID_RD;
                end
                S_INS_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        len_reg        <= len_reg + CW'(1);
                        res_status_reg <= ST_OK;
                        res_id_reg     <= new_reg.task_id;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_INS_CHK;
                    end
                end
                S_INS_CHK:
                begin
                    if (later)
                    begin
                        idx_reg   <= idx_reg - CW'(1);
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        len_reg        <= len_reg + CW'(1);
                        res_status_reg <= ST_OK;
                        res_id_reg     <= new_reg.task_id;
                        state_reg      <= S_RESP;
                    end
                end
                S_CAN_RD:
                begin
                    if (idx_reg == len_reg)
                    begin
                        res_status_reg <= ST_NOT_FOUND;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_CAN_CHK;
                    end
                end
                S_CAN_CHK:
                begin
                    if (rd_data.task_id == cid_reg)
                    begin
                        state_reg <= S_SHF_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_CAN_RD;
                    end
                end
                S_SHF_RD:
                begin
                    if ((idx_reg + CW'(1)) >= len_reg)
                    begin
                        len_reg        <= len_reg - CW'(1);
                        res_status_reg <= ST_OK;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_SHF_WR;
                    end
                end
                S_SHF_WR:
                begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_SHF_RD;
                end
                S_RESP:
                begin
                    // wait here while the previous result is still held
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= res_status_reg;
                        assigned_id_reg <= res_id_reg;
                        entry_count_reg <= len_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign assigned_id = assigned_id_reg;
    assign entry_count = entry_count_reg;

    assign out_hold = out_valid_reg && !out_ready;
    assign out_word = {status_reg, assigned_id_reg, entry_count_reg};

    `STTQ_ASSERT(a_len_bound, len_reg <= FULL_CNT, "queue length above depth")
    `STTQ_ASSERT(a_busy_after_xfer, in_xfer |=> !in_ready, "took a transfer but stayed idle")
    `STTQ_ASSERT(a_no_idle_write, wr_en |-> !in_ready, "memory write while idle")
    `STTQ_ASSERT(a_out_hold, out_hold |=> (out_valid_reg && $stable(out_word)), "stalled result lost")

endmodule

/* bench/sorted_timer_task_queue_core_tb.sv */
// ----------------------------------------------------------------------------
// Sorted timer task queue testbench
// Drives submit and cancel operations with random sender gaps and receiver
// stalls, predicts each result from a behavioral copy of the queue, and
// compares status, assigned id and entry count per result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_timer_task_queue_core_tb;
    import sttq_pkg::*;

    localparam int DEPTH      = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam bit OP_SUBMIT  = 1'b0;
    localparam bit OP_CANCEL  = 1'b1;

    typedef struct {
        bit               op;
        bit [63:0]        due;
        bit [31:0]        handler;
        bit [31:0]        argument;
        bit signed [23:0] cid;
    } op_item_t;

    typedef struct {
        op_status_t st;
        bit [22:0]  id;
        bit [6:0]   count;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic operation = 1'b0;
    logic [63:0] due_time = '0;
    logic [31:0] handler_ref = '0;
    logic [31:0] argument_ref = '0;
    logic signed [23:0] cancel_id = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [22:0] assigned_id;
    logic [6:0] entry_count;

    sorted_timer_task_queue_core #(.QUEUE_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .due_time(due_time),
        .handler_ref(handler_ref), .argument_ref(argument_ref),
        .cancel_id(cancel_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .assigned_id(assigned_id), .entry_count(entry_count)
    );

    always #5 clk = ~clk;

    // shadow of the task queue
    bit [63:0] q_time[$];
    bit [22:0] q_id[$];
    bit [22:0] last_id;

    op_item_t pending_ops[$];
    outcome_t expected_results[$];
    int errors = 0;
    int sent = 0, received = 0, full_hits = 0, wraps = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;
    bit hold_rx = 1'b0;
    bit accepted_in = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit id_queued(input bit [22:0] id);
        foreach (q_id[i]) if (q_id[i] == id) return 1'b1;
        return 1'b0;
    endfunction

    // result of one operation on the shadow queue
    function automatic outcome_t apply_operation(input op_item_t it);
        outcome_t r;
        int pos;
        r.id = '0;
        if (it.op == OP_SUBMIT) begin
            if (it.handler == 0) r.st = ST_BAD_ARGS;
            else begin
                for (int k = 0; k <= DEPTH; k++) begin
                    last_id = last_id + 23'd1;
                    if (last_id == 0) wraps++;
                    if (!id_queued(last_id)) break;
                end
                if (q_id.size() >= DEPTH) begin
                    r.st = ST_FULL;
                    full_hits++;
                end else begin
                    pos = 0;
                    while (pos < q_time.size() && q_time[pos] <= it.due) pos++;
                    q_time.insert(pos, it.due);
                    q_id.insert(pos, last_id);
                    r.st = ST_OK;
                    r.id = last_id;
                end
            end
        end else if (it.cid[23]) r.st = ST_INVALID_ID;
        else begin
            r.st = ST_NOT_FOUND;
            foreach (q_id[i]) if (q_id[i] == it.cid[22:0]) begin
                q_id.delete(i);
                q_time.delete(i);
                r.st = ST_OK;
                break;
            end
        end
        r.count = 7'(q_id.size());
        return r;
    endfunction

    function automatic op_item_t make_submit(input bit [63:0] t, input bit [31:0] h);
        op_item_t it;
        it.op = OP_SUBMIT;
        it.due = t;
        it.handler = h;
        it.argument = $urandom;
        it.cid = 24'($urandom);    // ignored on submit
        return it;
    endfunction

    function automatic op_item_t make_cancel(input bit signed [23:0] c);
        op_item_t it;
        it.op = OP_CANCEL;
        it.cid = c;
        it.due = {$urandom, $urandom};   // ignored on cancel
        it.handler = $urandom;
        it.argument = $urandom;
        return it;
    endfunction

    // small time range so equal due times occur often
    function automatic bit [63:0] rand_due();
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(0, 15));
            1: return {$urandom, $urandom};
            2: return 64'hffff_ffff_ffff_fff0 | 64'($urandom_range(0, 15));
            default: return 64'($urandom_range(0, 1000));
        endcase
    endfunction

    // Cancel targets are picked blindly, mostly from a low id range; the check uses
    // the shadow queue at accept time.
    initial begin
        op_item_t it;
        bit [22:0] pick;
        pending_ops.push_back(make_submit(64'd0, 32'd0));            // zero handler
        pending_ops.push_back(make_cancel(-24'sd1));                  // negative id
        pending_ops.push_back(make_cancel(24'sh800000));
        pending_ops.push_back(make_cancel(24'sd5));                   // not found
        pending_ops.push_back(make_submit(64'hffff_ffff_ffff_ffff, 32'hffff_ffff));
        pending_ops.push_back(make_submit(64'd0, 32'd1));
        pending_ops.push_back(make_submit(64'd7, 32'h8000_0000));
        pending_ops.push_back(make_submit(64'd7, 32'h1234_5678));     // equal time, FIFO
        pending_ops.push_back(make_submit(64'd7, 32'h5555_aaaa));
        pending_ops.push_back(make_cancel(24'sd3));                   // middle entry
        pending_ops.push_back(make_cancel(24'sd3));                   // already gone
        pending_ops.push_back(make_cancel(24'sd1));
        pending_ops.push_back(make_cancel(24'sh7fffff));
        for (int n = 0; n < 460; n++) begin
            if ($urandom_range(0, 99) < 55) begin
                it = make_submit(rand_due(), ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom);
            end else if ($urandom_range(0, 9) < 7) begin
                // cancel an id from a low range: 0 to 90
                pick = 23'($urandom_range(0, 90));
                it = make_cancel({1'b0, pick});
            end else begin
                it = make_cancel(24'($urandom));
            end
            pending_ops.push_back(it);
            // phase that fills the queue and overflows it
            if (n == 250)
                for (int k = 0; k < DEPTH + 6; k++)
                    pending_ops.push_back(make_submit(rand_due(), $urandom | 32'd1));
        end
        // sweep of cancels over the low ids
        for (int k = 0; k < 150; k++) pending_ops.push_back(make_cancel(24'(k)));
        stim_done = 1'b1;
    end

    // driver: bursts and gaps, payload changes on the falling edge
    int burst_left = 0, gap_left = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || accepted_in) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    op_item_t it;
                    it = pending_ops.pop_front();
                    operation <= it.op;
                    due_time <= it.due;
                    handler_ref <= it.handler;
                    argument_ref <= it.argument;
                    cancel_id <= it.cid;
                    in_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                    end
                    burst_left--;
                    if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0
                                                    : $urandom_range(1, 8);
                end else in_valid <= 1'b0;
            end
        end
    end

    // acceptance and prediction at the rising edge
    always @(posedge clk) begin
        accepted_in <= 1'b0;
        if (rst_n && in_valid && in_ready) begin
            op_item_t it;
            it.op = operation;
            it.due = due_time;
            it.handler = handler_ref;
            it.argument = argument_ref;
            it.cid = cancel_id;
            expected_results.push_back(apply_operation(it));
            accepted_in <= 1'b1;
            sent++;
        end
    end

    // receiver stall pattern, with one long hold-off
    int rx_phase = 0, hold_count = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            rx_phase++;
            if (hold_count == 0 && sent > 150 && sent < 160 && !hold_rx) begin
                hold_rx = 1'b1;
                hold_count = 400;
            end
            if (hold_count > 0) begin
                hold_count--;
                out_ready <= 1'b0;
            end else if ((rx_phase / 50) % 3 == 0) out_ready <= 1'b1;
            else out_ready <= ($urandom_range(0, 3) != 0) && (rx_phase % 7 != 3);
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            outcome_t e;
            received++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, results vs operations", received, sent);
            end else begin
                e = expected_results.pop_front();
                if (status !== e.st) report_mismatch("status", status, e.st);
                if (assigned_id !== e.id) report_mismatch("assigned_id", assigned_id, e.id);
                if (entry_count !== e.count)
                    report_mismatch("entry_count", entry_count, e.count);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && pending_ops.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge clk);
        $display("Ran %0d operations, %0d results; queue-full rejects %0d, id wraps %0d.",
                 sent, received, full_hits, wraps);
        if (errors == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
